[hw/rtl/btok_pkg.sv]
// Shared types, widths and codes for the bencode stream tokenizer.
`default_nettype none

package btok_pkg;

    localparam int MAX_DEPTH_DEF = 16;
    localparam int LEN_BITS_DEF  = 32;

    localparam int EV_W    = 3;
    localparam int DEPTH_W = 5;
    localparam int ROLE_W  = 2;
    localparam int INT_W   = 63;
    localparam int ERR_W   = 3;

    // token event codes
    localparam logic [EV_W-1:0] EV_LIST_OPEN  = 3'd0;
    localparam logic [EV_W-1:0] EV_LIST_CLOSE = 3'd1;
    localparam logic [EV_W-1:0] EV_DICT_OPEN  = 3'd2;
    localparam logic [EV_W-1:0] EV_DICT_CLOSE = 3'd3;
    localparam logic [EV_W-1:0] EV_INT        = 3'd4;
    localparam logic [EV_W-1:0] EV_STR_BYTE   = 3'd5;
    localparam logic [EV_W-1:0] EV_EMPTY_STR  = 3'd6;
    localparam logic [EV_W-1:0] EV_ERROR      = 3'd7;

    // token roles
    localparam logic [ROLE_W-1:0] ROLE_TOP   = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_ELEM  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_KEY   = 2'd2;
    localparam logic [ROLE_W-1:0] ROLE_VALUE = 2'd3;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 3'd1;
    localparam logic [ERR_W-1:0] ERR_KEY        = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DEPTH      = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NUM        = 3'd4;

    // container kind, bit 0 of a stack entry; bit 1 is the value-next phase
    localparam logic KIND_LIST = 1'b0;
    localparam logic KIND_DICT = 1'b1;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       restart;
    } in_beat_t;

    typedef struct packed {
        logic [EV_W-1:0]    event_res;
        logic [DEPTH_W-1:0] depth;
        logic [ROLE_W-1:0]  role;
        logic [INT_W-1:0]   int_value;
        logic [7:0]         data_byte;
        logic               last_byte;
        logic [ERR_W-1:0]   error_code;
    } out_beat_t;

    // classified byte as queued between front and back
    typedef struct packed {
        logic       restart;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_l;
        logic       is_d;
        logic       is_i;
        logic       is_e;
        logic       is_colon;
        logic [7:0] raw;
    } byte_class_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        logic flip;
        logic kind;
    } stack_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/btok_front.sv]
// Front end: takes input beats, classifies each byte, holds them in a two-entry queue.
`default_nettype none

module btok_front
    import btok_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire in_beat_t    byte_beat,
    output logic             head_valid,
    output byte_class_t      head,
    input  wire logic        head_pop
);

    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    byte_class_t cls;
    byte_class_t q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic [7:0]  dig_full;

    always_comb
    begin
        dig_full     = byte_beat.byte_in - CH_ZERO;
        cls.raw      = byte_beat.byte_in;
        cls.restart  = byte_beat.restart;
        cls.is_digit = (byte_beat.byte_in >= CH_ZERO) && (byte_beat.byte_in <= CH_NINE);
        cls.digit    = cls.is_digit ? dig_full[3:0] : 4'd0;
        cls.is_l     = byte_beat.byte_in == CH_L;
        cls.is_d     = byte_beat.byte_in == CH_D;
        cls.is_i     = byte_beat.byte_in == CH_I;
        cls.is_e     = byte_beat.byte_in == CH_E;
        cls.is_colon = byte_beat.byte_in == CH_COLON;
    end

    assign byte_ready = count_reg != 2'd2;
    assign push       = byte_valid && byte_ready;
    assign head_valid = count_reg != 2'd0;
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = head_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(head_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/btok_stack.sv]
// Container stack: top entry and the one below in registers, deeper entries in a memory.
`default_nettype none

module btok_stack
    import btok_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    localparam int SPW = $clog2(MAX_DEPTH + 1),
    localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire stack_cmd_t   cmd,
    output logic [SPW-1:0]    sp,
    output logic [1:0]        top,
    output logic [1:0]        below
);

    logic [1:0]     mem [MAX_DEPTH];
    logic [SPW-1:0] sp_reg, sp_next, sp_e;
    logic [1:0]     top_reg, top_next;
    logic [1:0]     below_reg;
    logic [SPW:0]   wr_tmp, rd_tmp;
    logic [AW-1:0]  wr_addr, rd_addr;

    assign sp    = sp_reg;
    assign top   = top_reg;
    assign below = below_reg;

    always_comb
    begin
        sp_e = cmd.clear ? '0 : sp_reg;
        if (cmd.push)
            sp_next = sp_e + 1'b1;
        else if (cmd.pop)
            sp_next = sp_e - 1'b1;
        else
            sp_next = sp_e;

        if (cmd.push)
            top_next = {1'b0, cmd.kind};
        else if (cmd.pop)
            top_next = cmd.flip ? (below_reg ^ {below_reg[0], 1'b0}) : below_reg;
        else
            top_next = cmd.flip ? (top_reg ^ {top_reg[0], 1'b0}) : top_reg;

        // old top spills to sp-1; below_reg tracks entry sp_next-2
        wr_tmp  = {1'b0, sp_e} - 1'b1;
        rd_tmp  = {1'b0, sp_next} - 2'd2;
        wr_addr = wr_tmp[AW-1:0];
        rd_addr = rd_tmp[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && (sp_e != '0))
        begin
            mem[wr_addr] <= top_reg;
        end
        below_reg <= cmd.push ? top_reg : mem[rd_addr];
        top_reg   <= top_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= '0;
        else
            sp_reg <= sp_next;
    end

endmodule

`default_nettype wire

[hw/rtl/btok_back.sv]
// Back end: parse state machine, number accumulator, string counter, output register.
`default_nettype none

module btok_back
    import btok_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int LEN_BITS  = LEN_BITS_DEF,
    localparam int SPW = $clog2(MAX_DEPTH + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  wire byte_class_t   head,
    output logic               head_pop,
    output logic               tok_valid,
    input  wire logic          tok_ready,
    output out_beat_t          tok_beat
);

    localparam logic [2:0] MODE_ITEM = 3'd0;
    localparam logic [2:0] MODE_INT  = 3'd1;
    localparam logic [2:0] MODE_LEN  = 3'd2;
    localparam logic [2:0] MODE_STR  = 3'd3;
    localparam logic [2:0] MODE_ERR  = 3'd4;

    localparam int PW = INT_W + 4;

    logic [2:0]          mode_reg, mode_next, mode_e;
    logic [INT_W-1:0]    acc_reg, acc_next, acc_e;
    logic [LEN_BITS-1:0] rem_reg, rem_next, rem_e;
    logic                out_vld_reg;
    out_beat_t           out_reg;

    stack_cmd_t     cmd;
    logic [SPW-1:0] sp;
    logic [SPW-1:0] sp_e;
    logic [1:0]     top, below;
    logic           fire;
    logic           emit;
    out_beat_t      res;
    logic [ROLE_W-1:0] role_cur, role_close;
    logic           key_due;
    logic [PW-1:0]  prod;
    logic           int_ovf, len_ovf;

    btok_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sp    (sp),
        .top   (top),
        .below (below)
    );

    assign fire      = head_valid && (!out_vld_reg || tok_ready);
    assign head_pop  = fire;
    assign tok_valid = out_vld_reg;
    assign tok_beat  = out_reg;

    always_comb
    begin
        // restart wipes state ahead of this byte
        mode_e = head.restart ? MODE_ITEM : mode_reg;
        acc_e  = head.restart ? '0 : acc_reg;
        rem_e  = head.restart ? '0 : rem_reg;
        sp_e   = head.restart ? '0 : sp;

        if (sp_e == '0)
            role_cur = ROLE_TOP;
        else if (top[0] == KIND_LIST)
            role_cur = ROLE_ELEM;
        else
            role_cur = top[1] ? ROLE_VALUE : ROLE_KEY;

        // role after a pop comes from the entry below
        if (sp_e < SPW'(2))
            role_close = ROLE_TOP;
        else if (below[0] == KIND_LIST)
            role_close = ROLE_ELEM;
        else
            role_close = below[1] ? ROLE_VALUE : ROLE_KEY;

        key_due = role_cur == ROLE_KEY;

        prod    = ({4'd0, acc_e} << 3) + ({4'd0, acc_e} << 1) + PW'(head.digit);
        int_ovf = (prod >> INT_W) != '0;
        len_ovf = (prod >> LEN_BITS) != '0;

        mode_next = mode_e;
        acc_next  = acc_e;
        rem_next  = rem_e;

        cmd.clear = head.restart;
        cmd.push  = 1'b0;
        cmd.pop   = 1'b0;
        cmd.flip  = 1'b0;
        cmd.kind  = head.is_d ? KIND_DICT : KIND_LIST;

        emit           = 1'b0;
        res.event_res  = EV_ERROR;
        res.depth      = DEPTH_W'(sp_e);
        res.role       = role_cur;
        res.int_value  = '0;
        res.data_byte  = 8'd0;
        res.last_byte  = 1'b0;
        res.error_code = ERR_NONE;

        case (mode_e)
            MODE_ITEM:
            begin
                if (head.is_l || head.is_d)
                begin
                    emit = 1'b1;
                    if (key_due)
                        res.error_code = ERR_KEY;
                    else if (sp_e >= SPW'(MAX_DEPTH))
                        res.error_code = ERR_DEPTH;
                    else
                    begin
                        res.event_res = head.is_l ? EV_LIST_OPEN : EV_DICT_OPEN;
                        cmd.push      = 1'b1;
                    end
                end
                else if (head.is_i)
                begin
                    if (key_due)
                    begin
                        emit           = 1'b1;
                        res.error_code = ERR_KEY;
                    end
                    else
                    begin
                        acc_next  = '0;
                        mode_next = MODE_INT;
                    end
                end
                else if (head.is_e)
                begin
                    emit = 1'b1;
                    if ((sp_e == '0) || ((top[0] == KIND_DICT) && top[1]))
                        res.error_code = ERR_UNEXPECTED;
                    else
                    begin
                        res.event_res = (top[0] == KIND_DICT) ? EV_DICT_CLOSE : EV_LIST_CLOSE;
                        res.depth     = DEPTH_W'(sp_e - 1'b1);
                        res.role      = role_close;
                        cmd.pop       = 1'b1;
                        cmd.flip      = 1'b1;
                    end
                end
                else if (head.is_digit)
                begin
                    acc_next  = INT_W'(head.digit);
                    mode_next = MODE_LEN;
                end
                else
                begin
                    emit           = 1'b1;
                    res.error_code = ERR_UNEXPECTED;
                end
            end
            MODE_INT:
            begin
                if (head.is_digit)
                begin
                    if (int_ovf)
                    begin
                        emit           = 1'b1;
                        res.error_code = ERR_NUM;
                    end
                    else
                        acc_next = prod[INT_W-1:0];
                end
                else if (head.is_e)
                begin
                    emit          = 1'b1;
                    res.event_res = EV_INT;
                    res.int_value = acc_e;
                    acc_next      = '0;
                    mode_next     = MODE_ITEM;
                    cmd.flip      = 1'b1;
                end
                else
                begin
                    emit           = 1'b1;
                    res.error_code = ERR_UNEXPECTED;
                end
            end
            MODE_LEN:
            begin
                if (head.is_digit)
                begin
                    if (len_ovf)
                    begin
                        emit           = 1'b1;
                        res.error_code = ERR_NUM;
                    end
                    else
                        acc_next = prod[INT_W-1:0];
                end
                else if (head.is_colon)
                begin
                    if (acc_e == '0)
                    begin
                        emit          = 1'b1;
                        res.event_res = EV_EMPTY_STR;
                        mode_next     = MODE_ITEM;
                        cmd.flip      = 1'b1;
                    end
                    else
                    begin
                        rem_next  = acc_e[LEN_BITS-1:0];
                        acc_next  = '0;
                        mode_next = MODE_STR;
                    end
                end
                else
                begin
                    emit           = 1'b1;
                    res.error_code = ERR_UNEXPECTED;
                end
            end
            MODE_STR:
            begin
                emit          = 1'b1;
                res.event_res = EV_STR_BYTE;
                res.data_byte = head.raw;
                res.last_byte = rem_e <= LEN_BITS'(1);
                if (rem_e != '0)
                    rem_next = rem_e - 1'b1;
                if (rem_e <= LEN_BITS'(1))
                begin
                    mode_next = MODE_ITEM;
                    cmd.flip  = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_ERR;
            end
        endcase

        if (emit && (res.event_res == EV_ERROR))
            mode_next = MODE_ERR;

        if (!fire)
        begin
            cmd.clear = 1'b0;
            cmd.push  = 1'b0;
            cmd.pop   = 1'b0;
            cmd.flip  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ITEM;
            acc_reg     <= '0;
            rem_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                mode_reg    <= mode_next;
                acc_reg     <= acc_next;
                rem_reg     <= rem_next;
                out_vld_reg <= emit;
            end
            else if (tok_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bencode_stream_tokenizer.sv]
// Top level of the bencode stream tokenizer: front queue, parse back end, checks.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+---------------------------------
//  byte     | in  | byte_valid / byte_ready  | byte_beat (in_beat_t)
//  tok      | out | tok_valid  / tok_ready   | tok_beat  (out_beat_t)
//
// One byte beat per cycle sustained while tok_ready is high; each byte yields
// zero or one token beat. A beat is first written into the two-entry queue, then
// the parse state machine consumes it and loads the output register in one step.
// Reset clears the parse mode, stack pointer, accumulator and string count;
// the stack memory itself is not cleared and needs no clearing pass.
// With tok_ready low and a token held, the queue fills after two more beats
// and byte_ready drops; the output register is reloaded in the same cycle it is taken.
`default_nettype none

module bencode_stream_tokenizer
    import btok_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int LEN_BITS  = LEN_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    output logic            byte_ready,
    input  wire in_beat_t   byte_beat,
    output logic            tok_valid,
    input  wire logic       tok_ready,
    output out_beat_t       tok_beat
);

    logic        head_valid;
    byte_class_t head;
    logic        head_pop;

    // front: classify and queue
    btok_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_beat  (byte_beat),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // back: parse, stack, emit
    btok_back #(
        .MAX_DEPTH (MAX_DEPTH),
        .LEN_BITS  (LEN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok_beat   (tok_beat)
    );

    // error beats and only error beats carry an error code
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid |-> ((tok_beat.event_res == EV_ERROR) == (tok_beat.error_code != ERR_NONE)))
        else $error("error code does not match event");

    // last mark appears only on string bytes
    a_last_str: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && tok_beat.last_byte) |-> (tok_beat.event_res == EV_STR_BYTE))
        else $error("last mark on non-string event");

    // a value only rides on integer events
    a_int_val: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (tok_beat.int_value != '0)) |-> (tok_beat.event_res == EV_INT))
        else $error("integer value on non-integer event");

    // front backpressure only when the queue holds beats
    a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> head_valid)
        else $error("byte_ready low with empty queue");

endmodule

`default_nettype wire
